// ===== hdl/ncfp_pkg.sv =====
// Shared types and constants for the NMEA command frame parser.
// No dependencies; every other file of the block but ncfp_if.sv refers to this package.
package ncfp_pkg;

  localparam int unsigned MAX_FRAME_DEF = 200;

  // Character codes used by the frame syntax.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // Command words, first character in the low byte.
  localparam logic [39:0] WORD_HOMEL = 40'h4C_45_4D_4F_48;
  localparam logic [39:0] WORD_HOMER = 40'h52_45_4D_4F_48;
  localparam logic [31:0] WORD_STLF  = 32'h46_4C_54_53;
  localparam logic [31:0] WORD_STRG  = 32'h47_52_54_53;
  localparam logic [31:0] WORD_STAT  = 32'h54_41_54_53;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_FORMAT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOME_LEFT  = 3'd0,
    CMD_HOME_RIGHT = 3'd1,
    CMD_STEP_LEFT  = 3'd2,
    CMD_STEP_RIGHT = 3'd3,
    CMD_STATUS     = 3'd4,
    CMD_UNKNOWN    = 3'd5
  } command_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        command;
    logic signed [31:0] speed;
    logic signed [31:0] distance;
    logic [7:0]        computed_sum;
  } result_t;

endpackage

// ===== hdl/ncfp_if.sv =====
// Handshake channel interfaces for the NMEA command frame parser.
// Depends on nothing; the result channel carries the widths of ncfp_pkg::result_t.
interface ncfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ncfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [2:0]         command;
  logic signed [31:0] speed;
  logic signed [31:0] distance;
  logic [7:0]         computed_sum;

  modport source (output valid, output status, output command, output speed,
                  output distance, output computed_sum, input ready);
  modport sink   (input valid, input status, input command, input speed,
                  input distance, input computed_sum, output ready);
  modport mon    (input valid, input ready, input status, input command, input speed,
                  input distance, input computed_sum);
endinterface

// ===== hdl/ncfp_frame.sv =====
// Frame state and per-byte update of the NMEA command frame parser.
// Depends on ncfp_pkg for character codes, command words and the result type.
module ncfp_frame #(
  parameter int unsigned MAX_FRAME = ncfp_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              emit_req,
  output ncfp_pkg::result_t result
);

  localparam int unsigned FLAG_NEG     = 0;
  localparam int unsigned FLAG_STARTED = 1;
  localparam int unsigned FLAG_DONE    = 2;

  typedef enum logic [3:0] {
    SEC_DATA = 4'b0001,
    SEC_HI   = 4'b0010,
    SEC_LO   = 4'b0100,
    SEC_DONE = 4'b1000
  } section_t;

  typedef enum logic [2:0] {
    FLD_CMD   = 3'b001,
    FLD_SPEED = 3'b010,
    FLD_DIST  = 3'b100
  } field_t;

  typedef struct packed {
    logic        in_frame;
    logic [7:0]  len;
    logic [7:0]  xsum;
    section_t    sec;
    logic [7:0]  rsum;
    logic        fbad;
    logic [39:0] head;
    field_t      fld;
    logic [31:0] spd;
    logic [31:0] dst;
    logic [2:0]  nflg;
  } state_t;

  typedef struct packed {
    logic [2:0]  flags;
    logic [31:0] acc;
  } num_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam state_t STATE_CLR = '{
    in_frame: 1'b0, len: 8'd0, xsum: 8'd0, sec: SEC_DATA, rsum: 8'd0, fbad: 1'b0,
    head: 40'd0, fld: FLD_CMD, spd: 32'd0, dst: 32'd0, nflg: 3'd0
  };

  // One character of a decimal field, read the way atoi reads it.
  function automatic num_t num_step(input logic [2:0] flags, input logic [31:0] acc,
                                    input logic [7:0] c);
    num_t        r;
    logic        digit;
    logic [31:0] dval;
    logic [31:0] times10;
    r       = '{flags: flags, acc: acc};
    digit   = (c >= ncfp_pkg::CH_ZERO) && (c <= ncfp_pkg::CH_NINE);
    dval    = {28'd0, c[3:0]};
    times10 = (acc << 3) + (acc << 1);
    if (!flags[FLAG_DONE]) begin
      if (!flags[FLAG_STARTED] &&
          ((c == ncfp_pkg::CH_SPACE) || ((c >= ncfp_pkg::CH_TAB) && (c <= ncfp_pkg::CH_CR)))) begin
        r.flags = flags;
      end else if (!flags[FLAG_STARTED] &&
                   ((c == ncfp_pkg::CH_PLUS) || (c == ncfp_pkg::CH_MINUS))) begin
        r.flags[FLAG_STARTED] = 1'b1;
        if (c == ncfp_pkg::CH_MINUS) r.flags[FLAG_NEG] = 1'b1;
      end else if (!digit) begin
        r.flags[FLAG_DONE] = 1'b1;
      end else begin
        r.flags[FLAG_STARTED] = 1'b1;
        r.acc = flags[FLAG_NEG] ? (times10 - dval) : (times10 + dval);
      end
    end
    return r;
  endfunction

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r = '{ok: 1'b0, val: 4'd0};
    if ((c >= ncfp_pkg::CH_ZERO) && (c <= ncfp_pkg::CH_NINE)) begin
      r = '{ok: 1'b1, val: c[3:0]};
    end else if (((c >= ncfp_pkg::CH_UA) && (c <= ncfp_pkg::CH_UF)) ||
                 ((c >= ncfp_pkg::CH_LA) && (c <= ncfp_pkg::CH_LF_HEX))) begin
      r = '{ok: 1'b1, val: 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  state_t      state_r;
  state_t      state_nxt;
  logic [7:0]  len_inc;
  logic        fb;
  logic        fmt_err;
  hex_t        hx;
  num_t        nr;

  always_comb begin
    state_nxt = state_r;
    len_inc   = (state_r.len == 8'hFF) ? state_r.len : (state_r.len + 8'd1);
    fb        = state_r.fbad | (len_inc > 8'(MAX_FRAME));
    emit_req  = state_r.in_frame && (rx_byte == ncfp_pkg::CH_LF);
    hx        = hex_value(rx_byte);
    nr        = '{flags: state_r.nflg, acc: 32'd0};

    if (!state_r.in_frame) begin
      if (rx_byte == ncfp_pkg::CH_DOLLAR) begin
        state_nxt          = STATE_CLR;
        state_nxt.in_frame = 1'b1;
        state_nxt.len      = 8'd1;
      end
    end else if (emit_req) begin
      state_nxt = STATE_CLR;
    end else begin
      state_nxt.len  = len_inc;
      state_nxt.fbad = fb;

      // The first five characters after the dollar sign name the command.
      for (int k = 0; k < 5; k++) begin
        if (state_r.len == 8'(k + 1)) state_nxt.head[8*k +: 8] = rx_byte;
      end

      unique case (state_r.sec)
        SEC_DATA: begin
          if (rx_byte == ncfp_pkg::CH_STAR) state_nxt.sec = SEC_HI;
          else state_nxt.xsum = state_r.xsum ^ rx_byte;
        end
        SEC_HI, SEC_LO: begin
          if (!hx.ok) state_nxt.fbad = 1'b1;
          state_nxt.rsum = {state_r.rsum[3:0], hx.val};
          state_nxt.sec  = (state_r.sec == SEC_HI) ? SEC_LO : SEC_DONE;
        end
        SEC_DONE: state_nxt.sec = SEC_DONE;
        default:  state_nxt.sec = SEC_DONE;
      endcase

      unique case (state_r.fld)
        FLD_CMD: begin
          if (rx_byte == ncfp_pkg::CH_COMMA) begin
            state_nxt.fld  = FLD_SPEED;
            state_nxt.nflg = 3'd0;
          end
        end
        FLD_SPEED: begin
          if (rx_byte == ncfp_pkg::CH_COMMA) begin
            state_nxt.fld  = FLD_DIST;
            state_nxt.nflg = 3'd0;
          end else begin
            nr             = num_step(state_r.nflg, state_r.spd, rx_byte);
            state_nxt.nflg = nr.flags;
            state_nxt.spd  = nr.acc;
          end
        end
        FLD_DIST: begin
          if (rx_byte == ncfp_pkg::CH_CR) begin
            state_nxt.nflg[FLAG_DONE] = 1'b1;
          end else begin
            nr             = num_step(state_r.nflg, state_r.dst, rx_byte);
            state_nxt.nflg = nr.flags;
            state_nxt.dst  = nr.acc;
          end
        end
        default: state_nxt.fld = FLD_DIST;
      endcase
    end
  end

  // Result of a frame closed by the current byte.
  always_comb begin
    fmt_err             = fb | (state_r.sec != SEC_DONE);
    result.computed_sum = state_r.xsum;
    result.command      = ncfp_pkg::CMD_UNKNOWN;
    result.speed        = 32'sd0;
    result.distance     = 32'sd0;
    if (fmt_err) result.status = ncfp_pkg::ST_FORMAT;
    else if (state_r.rsum != state_r.xsum) result.status = ncfp_pkg::ST_BAD_SUM;
    else result.status = ncfp_pkg::ST_OK;
    if (result.status == ncfp_pkg::ST_OK) begin
      priority if (state_r.head == ncfp_pkg::WORD_HOMEL) begin
        result.command = ncfp_pkg::CMD_HOME_LEFT;
      end else if (state_r.head == ncfp_pkg::WORD_HOMER) begin
        result.command = ncfp_pkg::CMD_HOME_RIGHT;
      end else if (state_r.head[31:0] == ncfp_pkg::WORD_STLF) begin
        result.command  = ncfp_pkg::CMD_STEP_LEFT;
        result.speed    = state_r.spd;
        result.distance = state_r.dst;
      end else if (state_r.head[31:0] == ncfp_pkg::WORD_STRG) begin
        result.command  = ncfp_pkg::CMD_STEP_RIGHT;
        result.speed    = state_r.spd;
        result.distance = state_r.dst;
      end else if (state_r.head[31:0] == ncfp_pkg::WORD_STAT) begin
        result.command = ncfp_pkg::CMD_STATUS;
      end else begin
        result.command = ncfp_pkg::CMD_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLR;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/nmea_command_frame_parser_unit.sv =====
// Top level of the NMEA command frame parser: input word register, frame logic, result register.
// Depends on ncfp_pkg, the channel interfaces in ncfp_if.sv and the ncfp_frame module.
// Throughput: one byte word per clock cycle, sustained, as long as results are taken.
// A closing newline is captured in the input word register, then its result word is loaded into
// the result register that drives the output channel; bytes that cause no result only update state.
// Reset: synchronous, active low; clears the frame state and both valid flags.
module nmea_command_frame_parser_unit #(
  parameter int unsigned MAX_FRAME = ncfp_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ncfp_in_if.sink           in_ch,
  ncfp_out_if.source        out_ch
);

  // The input register holds one byte word. It is consumed (a step of the frame
  // logic) whenever it holds a byte, unless that byte closes a frame and the
  // result register is still occupied by a result that has not been taken.
  logic              byte_vld_r;
  logic              byte_vld_nxt;
  logic [7:0]        byte_r;
  logic              in_acc;
  logic              step;
  logic              emit_req;
  logic              out_free;
  logic              out_vld_r;
  logic              out_vld_nxt;
  ncfp_pkg::result_t res;
  ncfp_pkg::result_t res_r;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign step        = byte_vld_r && (!emit_req || out_free);
  assign in_ch.ready = !byte_vld_r || step;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_acc) byte_vld_nxt = 1'b1;
    else if (step) byte_vld_nxt = 1'b0;
  end

  // The result register is loaded when a closing newline is stepped; a held
  // result stays put until the sink takes it.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step && emit_req) out_vld_nxt = 1'b1;
    else if (out_ch.ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) byte_r <= in_ch.rx_byte;
    if (step && emit_req) res_r <= res;
  end

  ncfp_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (byte_r),
    .emit_req (emit_req),
    .result   (res)
  );

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.command      = res_r.command;
  assign out_ch.speed        = res_r.speed;
  assign out_ch.distance     = res_r.distance;
  assign out_ch.computed_sum = res_r.computed_sum;

endmodule

// ===== hdl/ncfp_checker.sv =====
// Port-level checks for the NMEA command frame parser, attached by bind.
// Depends on ncfp_pkg; watches the result channel signals of the top level.
module ncfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [2:0]         out_command,
  input logic signed [31:0] out_speed,
  input logic signed [31:0] out_distance,
  input logic [7:0]         out_computed_sum
);

  // A word that is not ok never carries a command or numbers.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ncfp_pkg::ST_OK) |->
      (out_command == ncfp_pkg::CMD_UNKNOWN) && (out_speed == 32'sd0) &&
      (out_distance == 32'sd0))
    else $error("result not ok but carries command or numbers");

  // Only step commands carry numeric fields.
  a_no_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command != ncfp_pkg::CMD_STEP_LEFT) &&
    (out_command != ncfp_pkg::CMD_STEP_RIGHT) |->
      (out_speed == 32'sd0) && (out_distance == 32'sd0))
    else $error("numbers on a command without fields");

  // No result word survives reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result word holds its content.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_command) && $stable(out_speed) && $stable(out_distance) &&
      $stable(out_computed_sum))
    else $error("stalled result word changed or dropped");

endmodule

bind nmea_command_frame_parser_unit ncfp_checker u_ncfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_command      (out_ch.command),
  .out_speed        (out_ch.speed),
  .out_distance     (out_ch.distance),
  .out_computed_sum (out_ch.computed_sum)
);

// ===== test/testbench.sv =====
// Self-checking testbench for nmea_command_frame_parser_unit: byte frames in, result words out.
// Depends on ncfp_pkg and the channel interfaces in ncfp_if.sv; compares every result word
// against a cycle-free software parser of the frame syntax kept inside this module.
module testbench;

  localparam int unsigned FRAME_LIMIT = ncfp_pkg::MAX_FRAME_DEF;
  // Slowest run is roughly 1550 byte words at under half throughput plus receiver
  // stalls; the limit below leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0] octet_t;

  // How the checksum part of a generated frame is written.
  typedef enum {
    SUM_GOOD,
    SUM_LOWER,
    SUM_WRONG,
    SUM_NONE,
    SUM_SHORT,
    SUM_BAD_HEX
  } sum_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // The channel inputs are driven through these registers so that each has exactly
  // one driving process and a known value from time zero.
  logic   send_valid = 1'b0;
  octet_t send_byte = 8'h00;
  logic   take_ready = 1'b0;

  ncfp_in_if  in_ch();
  ncfp_out_if out_ch();

  assign in_ch.valid   = send_valid;
  assign in_ch.rx_byte = send_byte;
  assign out_ch.ready  = take_ready;

  nmea_command_frame_parser_unit #(.MAX_FRAME(FRAME_LIMIT)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Byte words waiting to be offered, and result words the parser owes us.
  octet_t            pending_bytes[$];
  ncfp_pkg::result_t awaited_results[$];

  int mismatches = 0;
  int cycle_count = 0;
  int frame_bytes_queued = 0;

  // Idle rates in percent; the stimulus process changes them between phases.
  int send_pct = 24;
  int recv_pct = 55;

  // Scratch space for building one frame.
  octet_t body_text[$];
  octet_t tail_text[$];

  string  cmd_heads[11] = '{"HOMEL", "HOMER", "STLF", "STRG", "STAT", "STLF", "STRG",
                            "HOMEX", "STL", "STRGX", "STA"};
  string  head_letters = "HOMELRSTFGA";
  octet_t blank_chars[5] = '{ncfp_pkg::CH_SPACE, ncfp_pkg::CH_TAB, 8'h0B, 8'h0C,
                             ncfp_pkg::CH_CR};

  // --------------------------------------------------------------------------
  // Frame parser state, mirroring what the block keeps between byte words.
  // --------------------------------------------------------------------------
  bit          fr_open = 1'b0;
  logic [7:0]  fr_len = '0;
  logic [7:0]  fr_xor = '0;
  logic [1:0]  fr_section = '0;   // 0 before the star, 1 and 2 hex digits, 3 after them
  logic [7:0]  fr_rsum = '0;
  bit          fr_bad = 1'b0;
  logic [39:0] fr_head = '0;      // first five characters after the dollar sign
  logic [1:0]  fr_commas = '0;
  logic [31:0] fr_speed = '0;
  logic [31:0] fr_dist = '0;
  bit          fr_neg = 1'b0;
  bit          fr_started = 1'b0;
  bit          fr_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: a hung handshake or a result that never shows up ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int hex_nibble(octet_t c);
    if (c >= ncfp_pkg::CH_ZERO && c <= ncfp_pkg::CH_NINE) return int'(c - ncfp_pkg::CH_ZERO);
    if (c >= ncfp_pkg::CH_UA && c <= ncfp_pkg::CH_UF) return int'(c - ncfp_pkg::CH_UA) + 10;
    if (c >= ncfp_pkg::CH_LA && c <= ncfp_pkg::CH_LF_HEX) return int'(c - ncfp_pkg::CH_LA) + 10;
    return -1;
  endfunction

  task automatic clear_frame();
    fr_open    = 1'b0;
    fr_len     = '0;
    fr_xor     = '0;
    fr_section = '0;
    fr_rsum    = '0;
    fr_bad     = 1'b0;
    fr_head    = '0;
    fr_commas  = '0;
    fr_speed   = '0;
    fr_dist    = '0;
    fr_neg     = 1'b0;
    fr_started = 1'b0;
    fr_done    = 1'b0;
  endtask

  // atoi-style digit accumulation: leading blanks, one optional sign, then digits;
  // the first other character freezes the field. Arithmetic wraps at 32 bits.
  task automatic number_step(inout logic [31:0] acc, input octet_t c);
    bit digit;
    digit = (c >= ncfp_pkg::CH_ZERO && c <= ncfp_pkg::CH_NINE);
    if (fr_done) return;
    if (!fr_started) begin
      if (c == ncfp_pkg::CH_SPACE || (c >= ncfp_pkg::CH_TAB && c <= ncfp_pkg::CH_CR)) return;
      if (c == ncfp_pkg::CH_PLUS || c == ncfp_pkg::CH_MINUS) begin
        fr_started = 1'b1;
        if (c == ncfp_pkg::CH_MINUS) fr_neg = 1'b1;
        return;
      end
      if (!digit) begin
        fr_done = 1'b1;
        return;
      end
      fr_started = 1'b1;
    end
    if (!digit) begin
      fr_done = 1'b1;
      return;
    end
    if (fr_neg) acc = acc * 32'd10 - {24'd0, c - ncfp_pkg::CH_ZERO};
    else acc = acc * 32'd10 + {24'd0, c - ncfp_pkg::CH_ZERO};
  endtask

  // Advances the parser by one accepted byte word; a newline inside a frame
  // closes it and queues the result word the block must produce.
  task automatic parse_byte(input octet_t c);
    logic [7:0]        at;
    int                nib;
    ncfp_pkg::result_t r;
    if (!fr_open) begin
      if (c == ncfp_pkg::CH_DOLLAR) begin
        clear_frame();
        fr_open = 1'b1;
        fr_len  = 8'd1;
      end
      return;
    end

    at = fr_len;
    if (fr_len != 8'd255) fr_len = fr_len + 8'd1;
    if (fr_len > FRAME_LIMIT) fr_bad = 1'b1;

    if (c == ncfp_pkg::CH_LF) begin
      // Both checksum digits must have been seen; format errors win over a bad sum.
      if (fr_section != 2'd3) fr_bad = 1'b1;
      if (fr_bad) r.status = ncfp_pkg::ST_FORMAT;
      else if (fr_rsum != fr_xor) r.status = ncfp_pkg::ST_BAD_SUM;
      else r.status = ncfp_pkg::ST_OK;
      r.command      = ncfp_pkg::CMD_UNKNOWN;
      r.speed        = '0;
      r.distance     = '0;
      r.computed_sum = fr_xor;
      if (r.status == ncfp_pkg::ST_OK) begin
        if (fr_head == ncfp_pkg::WORD_HOMEL) r.command = ncfp_pkg::CMD_HOME_LEFT;
        else if (fr_head == ncfp_pkg::WORD_HOMER) r.command = ncfp_pkg::CMD_HOME_RIGHT;
        else if (fr_head[31:0] == ncfp_pkg::WORD_STLF) begin
          r.command  = ncfp_pkg::CMD_STEP_LEFT;
          r.speed    = fr_speed;
          r.distance = fr_dist;
        end else if (fr_head[31:0] == ncfp_pkg::WORD_STRG) begin
          r.command  = ncfp_pkg::CMD_STEP_RIGHT;
          r.speed    = fr_speed;
          r.distance = fr_dist;
        end else if (fr_head[31:0] == ncfp_pkg::WORD_STAT) r.command = ncfp_pkg::CMD_STATUS;
      end
      awaited_results.push_back(r);
      clear_frame();
      return;
    end

    if (at >= 8'd1 && at <= 8'd5) fr_head[8 * (at - 1) +: 8] = c;

    case (fr_section)
      2'd0: begin
        if (c == ncfp_pkg::CH_STAR) fr_section = 2'd1;
        else fr_xor = fr_xor ^ c;
      end
      2'd1, 2'd2: begin
        nib = hex_nibble(c);
        if (nib < 0) begin
          fr_bad = 1'b1;
          nib = 0;
        end
        fr_rsum    = {fr_rsum[3:0], nib[3:0]};
        fr_section = fr_section + 2'd1;
      end
      default: ;
    endcase

    // Commas select the field; the distance field also stops at a carriage return.
    if (fr_commas == 2'd0) begin
      if (c == ncfp_pkg::CH_COMMA) begin
        fr_commas  = 2'd1;
        fr_neg     = 1'b0;
        fr_started = 1'b0;
        fr_done    = 1'b0;
      end
    end else if (fr_commas == 2'd1) begin
      if (c == ncfp_pkg::CH_COMMA) begin
        fr_commas  = 2'd2;
        fr_neg     = 1'b0;
        fr_started = 1'b0;
        fr_done    = 1'b0;
      end else number_step(fr_speed, c);
    end else begin
      if (c == ncfp_pkg::CH_CR) fr_done = 1'b1;
      else number_step(fr_dist, c);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the head of pending_bytes; a word that was not taken is held.
  // Idle gaps are random at send_pct.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit offer;
    bit pause;
    if (!rst_n) begin
      send_valid <= 1'b0;
    end else begin
      if (send_valid && in_ch.ready) void'(pending_bytes.pop_front());
      pause = ($urandom_range(99) < send_pct);
      if (send_valid && !in_ch.ready) offer = 1'b1;
      else offer = (pending_bytes.size() != 0) && !pause;
      send_valid <= offer;
      if (offer) send_byte <= pending_bytes[0];
    end
  end

  task automatic flag_field(string field, longint want, longint got);
    $error("%s: expected %0d, got %0d", field, want, got);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result word against the oldest expectation,
  // then feeds the byte word accepted at the same edge to the parser. Checking
  // first keeps a newline accepted now from being matched at this very edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ncfp_pkg::result_t want;
    bit                stall;
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else begin
      if (out_ch.valid && take_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status)
            flag_field("status", want.status, out_ch.status);
          if (out_ch.command !== want.command)
            flag_field("command", want.command, out_ch.command);
          if (out_ch.speed !== want.speed)
            flag_field("speed", want.speed, out_ch.speed);
          if (out_ch.distance !== want.distance)
            flag_field("distance", want.distance, out_ch.distance);
          if (out_ch.computed_sum !== want.computed_sum)
            flag_field("computed_sum", want.computed_sum, out_ch.computed_sum);
        end
      end
      if (send_valid && in_ch.ready) parse_byte(send_byte);
      stall = ($urandom_range(99) < recv_pct);
      take_ready <= !stall;
    end
  end

  // --------------------------------------------------------------------------
  // Frame construction.
  // --------------------------------------------------------------------------
  function automatic octet_t hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return ncfp_pkg::CH_ZERO + octet_t'(n);
    return (lower ? ncfp_pkg::CH_LA : ncfp_pkg::CH_UA) + octet_t'(n) - 8'd10;
  endfunction

  function automatic octet_t noise_byte(octet_t ban_a, octet_t ban_b);
    octet_t b;
    b = octet_t'($urandom_range(255));
    while (b == ban_a || b == ban_b) b = octet_t'($urandom_range(255));
    return b;
  endfunction

  task automatic send(octet_t b);
    pending_bytes.push_back(b);
    frame_bytes_queued++;
  endtask

  task automatic add_body(string s);
    int i;
    for (i = 0; i < s.len(); i++) body_text.push_back(s[i]);
  endtask

  // Wraps body_text in a dollar sign, the checksum part and tail_text, then a newline.
  task automatic queue_frame(sum_style_t style);
    octet_t sum;
    octet_t bad;
    int     i;
    sum = 8'h00;
    for (i = 0; i < body_text.size(); i++) sum = sum ^ body_text[i];
    send(ncfp_pkg::CH_DOLLAR);
    for (i = 0; i < body_text.size(); i++) send(body_text[i]);
    if (style == SUM_WRONG) sum = sum ^ octet_t'($urandom_range(1, 255));
    case (style)
      SUM_GOOD, SUM_WRONG, SUM_LOWER: begin
        send(ncfp_pkg::CH_STAR);
        send(hex_char(sum[7:4], style == SUM_LOWER));
        send(hex_char(sum[3:0], style == SUM_LOWER));
      end
      SUM_SHORT: begin
        send(ncfp_pkg::CH_STAR);
        send(hex_char(sum[7:4], 1'b0));
      end
      SUM_BAD_HEX: begin
        bad = octet_t'($urandom_range(255));
        while (hex_nibble(bad) >= 0 || bad == ncfp_pkg::CH_LF)
          bad = octet_t'($urandom_range(255));
        send(ncfp_pkg::CH_STAR);
        if ($urandom_range(1) == 0) begin
          send(bad);
          send(hex_char(sum[3:0], 1'b0));
        end else begin
          send(hex_char(sum[7:4], 1'b0));
          send(bad);
        end
      end
      default: ;
    endcase
    for (i = 0; i < tail_text.size(); i++) send(tail_text[i]);
    send(ncfp_pkg::CH_LF);
  endtask

  task automatic directed(string body, sum_style_t style, string tail, bit with_cr);
    int i;
    body_text.delete();
    tail_text.delete();
    add_body(body);
    for (i = 0; i < tail.len(); i++) tail_text.push_back(tail[i]);
    if (with_cr) tail_text.push_back(ncfp_pkg::CH_CR);
    queue_frame(style);
  endtask

  // A status frame padded so the whole frame, dollar and newline included, has frame_len bytes.
  task automatic long_frame(int frame_len);
    body_text.delete();
    tail_text.delete();
    add_body("STAT");
    while (body_text.size() < frame_len - 6) body_text.push_back(ncfp_pkg::CH_UA);
    tail_text.push_back(ncfp_pkg::CH_CR);
    queue_frame(SUM_GOOD);
  endtask

  // One numeric field: optional blanks, optional sign, zero to fourteen digits.
  task automatic add_number();
    int i;
    int n;
    int r;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    for (i = 0; i < n; i++) body_text.push_back(blank_chars[$urandom_range(0, 4)]);
    r = $urandom_range(5);
    if (r < 2) body_text.push_back(ncfp_pkg::CH_MINUS);
    else if (r == 2) body_text.push_back(ncfp_pkg::CH_PLUS);
    r = $urandom_range(19);
    if (r == 0) n = 0;
    else if (r < 3) n = $urandom_range(10, 14);
    else n = $urandom_range(1, 6);
    for (i = 0; i < n; i++)
      body_text.push_back(ncfp_pkg::CH_ZERO + octet_t'($urandom_range(9)));
  endtask

  // Mostly well-formed command frames with random fields; the rest carry bad
  // sums, broken checksum parts, odd heads, stray bytes or excess length.
  task automatic queue_random_frame();
    int         pick;
    int         fields;
    int         i;
    int         n;
    int         r;
    sum_style_t style;
    body_text.delete();
    tail_text.delete();

    pick = $urandom_range(0, 15);
    if (pick < 11) add_body(cmd_heads[pick]);
    else if (pick < 14) begin
      n = $urandom_range(2, 6);
      for (i = 0; i < n; i++)
        body_text.push_back(head_letters[$urandom_range(0, head_letters.len() - 1)]);
    end else begin
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) body_text.push_back(noise_byte(ncfp_pkg::CH_LF, ncfp_pkg::CH_STAR));
    end

    r = $urandom_range(9);
    if (r == 0) fields = 0;
    else if (r == 1) fields = 1;
    else if (r < 8) fields = 2;
    else fields = 3;
    for (i = 0; i < fields; i++) begin
      body_text.push_back(ncfp_pkg::CH_COMMA);
      add_number();
    end

    if ($urandom_range(7) == 0) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) body_text.push_back(noise_byte(ncfp_pkg::CH_LF, ncfp_pkg::CH_STAR));
    end
    // Now and then a frame near or past the length limit.
    if ($urandom_range(29) == 0) begin
      n = $urandom_range(185, 215);
      while (body_text.size() < n)
        body_text.push_back(ncfp_pkg::CH_LA + octet_t'($urandom_range(25)));
    end

    r = $urandom_range(99);
    if (r < 78) style = SUM_GOOD;
    else if (r < 84) style = SUM_LOWER;
    else if (r < 90) style = SUM_WRONG;
    else if (r < 93) style = SUM_NONE;
    else if (r < 96) style = SUM_SHORT;
    else style = SUM_BAD_HEX;

    r = $urandom_range(99);
    if (r < 65) tail_text.push_back(ncfp_pkg::CH_CR);
    else if (r < 90) begin
      n = (r < 80) ? 0 : $urandom_range(1, 3);
      for (i = 0; i < n; i++) tail_text.push_back(noise_byte(ncfp_pkg::CH_LF, ncfp_pkg::CH_CR));
      if (r >= 80) tail_text.push_back(ncfp_pkg::CH_CR);
    end else begin
      tail_text.push_back(ncfp_pkg::CH_CR);
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) tail_text.push_back(noise_byte(ncfp_pkg::CH_LF, ncfp_pkg::CH_LF));
    end
    queue_frame(style);

    // Line noise between frames; the block drops it while waiting for a dollar sign.
    n = $urandom_range(0, 2);
    for (i = 0; i < n; i++)
      pending_bytes.push_back(noise_byte(ncfp_pkg::CH_DOLLAR, ncfp_pkg::CH_DOLLAR));
  endtask

  task wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed frames, then three random phases with different idling.
  // --------------------------------------------------------------------------
  initial begin
    int base;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Extreme byte values and a newline outside any frame, all ignored.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(ncfp_pkg::CH_LF);

    directed("HOMEL", SUM_GOOD, "", 1'b1);
    directed("HOMER", SUM_LOWER, "", 1'b1);
    directed("STLF,100,-250", SUM_GOOD, "", 1'b1);
    directed("STRG, +2147483647,\t-2147483648", SUM_GOOD, "", 1'b1);
    // Values beyond 32 bits wrap around.
    directed("STLF,99999999999,-4294967297", SUM_GOOD, "", 1'b1);
    directed("STAT", SUM_GOOD, "", 1'b0);
    directed("QWXYZ,5,6", SUM_GOOD, "", 1'b1);
    directed("STRG,1,2", SUM_WRONG, "", 1'b1);
    // Missing star, only one checksum digit, and a non-hex checksum digit.
    directed("STAT", SUM_NONE, "", 1'b1);
    directed("HOMEL", SUM_SHORT, "", 1'b1);
    directed("HOMER", SUM_BAD_HEX, "", 1'b1);
    // A dollar sign inside a frame is an ordinary character.
    directed("ST$LF,3,4", SUM_GOOD, "", 1'b1);
    directed("STLF,,", SUM_GOOD, "", 1'b1);
    directed("STRG", SUM_GOOD, "", 1'b1);
    directed("STLF, - 5,+", SUM_GOOD, "", 1'b1);
    // Bytes after the checksum digits, before the carriage return.
    directed("STLF,12,34", SUM_GOOD, "xy", 1'b1);
    directed("STRG,-7,8", SUM_GOOD, "", 1'b1);
    directed("", SUM_NONE, "", 1'b0);

    body_text.delete();
    tail_text.delete();
    add_body("STAT");
    body_text.push_back(8'hFF);
    body_text.push_back(8'h00);
    body_text.push_back(8'h80);
    body_text.push_back(8'h7F);
    tail_text.push_back(ncfp_pkg::CH_CR);
    queue_frame(SUM_GOOD);

    // Exactly at the length limit, one past it, and past the saturation of the counter.
    long_frame(FRAME_LIMIT);
    long_frame(FRAME_LIMIT + 1);
    long_frame(300);

    base = frame_bytes_queued;
    while (frame_bytes_queued < base + 180) queue_random_frame();
    wait_drained();

    send_pct = 55;
    recv_pct = 24;
    while (frame_bytes_queued < base + 360) queue_random_frame();
    wait_drained();

    send_pct = 0;
    recv_pct = 0;
    while (frame_bytes_queued < base + 540) queue_random_frame();
    wait_drained();

    // Wait until every awaited result word has arrived, then give any stray
    // result word time to reach the monitor.
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
